// ===== design/fvn2d_pkg.sv =====
// package for the fractal value noise core
// widths, register reset values, config indexes and the lattice hash rom
// no dependencies
package fvn2d_pkg;

    localparam int MAX_OCTAVES_DEF   = 8;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W    = 32;
    localparam int FREQ_W     = 24;
    localparam int OCT_W      = 4;
    localparam int SEED_W     = 8;
    localparam int NOISE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int POS_W      = 40;
    localparam int POS_FRAC   = 32;
    localparam int LAT_W      = 8;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd65536;
    localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;
    localparam logic [SEED_W-1:0] SEED_RESET = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQUENCY = 2'd0,
        CFG_OCTAVES   = 2'd1,
        CFG_SEED      = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] LATTICE_ROM [0:255] = '{
        8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
        8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
        8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
        8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
        8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
        8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
        8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
        8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
        8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
        8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
        8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
        8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
        8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
        8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
        8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
        8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
        8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
        8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
        8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
        8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
        8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
        8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
        8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
        8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
        8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
        8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
        8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
        8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
        8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
        8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
        8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
        8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
    };

endpackage

// ===== design/fractal_value_noise_2d_core.sv =====
// fractal value noise core, 2-d, smoothstep blend, one octave lane per octave
// depends on fvn2d_pkg
// throughput: one transaction per cycle, set by the fully pipelined octave lanes
// and the reciprocal-multiply normalizer; an output stall freezes every stage
// reset: synchronous active low, clears valid bits and loads register defaults
module fractal_value_noise_2d_core
    import fvn2d_pkg::*;
#(
    parameter int MAX_OCTAVES   = MAX_OCTAVES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_W-1:0]    i_x_coord,
    input  logic [COORD_W-1:0]    i_y_coord,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [NOISE_W-1:0]    o_noise_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int F     = FRACTION_BITS;
    localparam int M     = MAX_OCTAVES;
    localparam int W     = LAT_W + F;
    localparam int DW    = $clog2(M + 1);
    localparam int AW    = W + M;
    localparam int XW    = 16 + M;
    localparam int S     = XW;
    localparam int NSTG  = 11;

    logic [FREQ_W-1:0] r_frequency;
    logic [OCT_W-1:0]  r_octaves;
    logic [SEED_W-1:0] r_seed;

    logic [NSTG-1:0] r_vld;
    logic            adv;

    assign adv         = !r_vld[NSTG-1] || !i_stall;
    assign o_stall     = !adv;
    assign o_valid     = r_vld[NSTG-1];
    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frequency <= FREQ_RESET;
            r_octaves   <= OCT_RESET;
            r_seed      <= SEED_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FREQUENCY: r_frequency <= i_cfg_data[FREQ_W-1:0];
                CFG_OCTAVES:   r_octaves   <= i_cfg_data[OCT_W-1:0];
                CFG_SEED:      r_seed      <= i_cfg_data[SEED_W-1:0];
                default:       r_frequency <= r_frequency;
            endcase
        end
    end

    // effective octave count and its divisor
    logic [DW-1:0] d_eff;
    logic [M-1:0]  denom;

    always_comb begin
        if (r_octaves == '0) begin
            d_eff = DW'(1);
        end else if ({1'b0, r_octaves} > (OCT_W+1)'(M)) begin
            d_eff = DW'(M);
        end else begin
            d_eff = DW'(r_octaves);
        end
    end

    assign denom = M'((64'd1 << d_eff) - 64'd1);

    logic [S:0] rcp_tab [2**DW];

    for (genvar gd = 0; gd < 2**DW; gd++) begin : g_rcp
        if (gd >= 1 && gd <= M) begin : g_on
            localparam logic [63:0] RC = (64'd1 << S) / ((64'd1 << gd) - 64'd1);
            assign rcp_tab[gd] = RC[S:0];
        end else begin : g_off
            assign rcp_tab[gd] = '0;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // stage 0 input, stage 1 scaled position
    logic [COORD_W-1:0] r_x, r_y;
    logic [POS_W-1:0]   r_px, r_py;
    logic [POS_W-1:0]   n_px, n_py;

    assign n_px = POS_W'(r_x * r_frequency);
    assign n_py = POS_W'(r_y * r_frequency);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x  <= i_x_coord;
            r_y  <= i_y_coord;
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    logic [AW-1:0] r_term [M];

    for (genvar gi = 0; gi < M; gi++) begin : g_lane
        logic [POS_W-1:0] qx, qy;
        logic [7:0]       ix, iy;
        logic [F-1:0]     fx, fy;
        logic [2*F-1:0]   fxx, fyy;
        logic [F+1:0]     n_tx, n_ty;
        logic [7:0]       n_row0, n_row1;

        logic [7:0]   r_ix, r_row0, r_row1;
        logic [F-1:0] r_sqx, r_sqy;
        logic [F+1:0] r_tx, r_ty;

        logic [2*F+1:0] wxp, wyp;
        logic [7:0]     n_c00, n_c10, n_c01, n_c11;
        logic [7:0]     r_c00, r_c10, r_c01, r_c11;
        logic [F:0]     r_wx, r_wy, r_wy2;

        logic signed [8:0]     dlo, dhi;
        logic signed [F+10:0]  plo, phi;
        logic signed [W+1:0]   n_lo_s, n_hi_s;
        logic [W-1:0]          r_lo, r_hi;

        logic signed [W:0]     dh;
        logic signed [W+F+2:0] p2;
        logic signed [W+F+2:0] p2s;
        logic [W-1:0]          n_n, r_n;
        logic [DW-1:0]         sh;

        assign qx = POS_W'(r_px << gi);
        assign qy = POS_W'(r_py << gi);
        assign ix = qx[POS_W-1:POS_FRAC];
        assign iy = qy[POS_W-1:POS_FRAC];
        assign fx = qx[POS_FRAC-1 -: F];
        assign fy = qy[POS_FRAC-1 -: F];
        assign fxx = fx * fx;
        assign fyy = fy * fy;
        assign n_tx = ((F+2)'(3) << F) - {1'b0, fx, 1'b0};
        assign n_ty = ((F+2)'(3) << F) - {1'b0, fy, 1'b0};
        assign n_row0 = LATTICE_ROM[8'(iy + r_seed)];
        assign n_row1 = LATTICE_ROM[8'(iy + 8'd1 + r_seed)];

        assign wxp   = r_sqx * r_tx;
        assign wyp   = r_sqy * r_ty;
        assign n_c00 = LATTICE_ROM[8'(r_row0 + r_ix)];
        assign n_c10 = LATTICE_ROM[8'(r_row0 + r_ix + 8'd1)];
        assign n_c01 = LATTICE_ROM[8'(r_row1 + r_ix)];
        assign n_c11 = LATTICE_ROM[8'(r_row1 + r_ix + 8'd1)];

        assign dlo    = $signed({1'b0, r_c10}) - $signed({1'b0, r_c00});
        assign dhi    = $signed({1'b0, r_c11}) - $signed({1'b0, r_c01});
        assign plo    = dlo * $signed({1'b0, r_wx});
        assign phi    = dhi * $signed({1'b0, r_wx});
        assign n_lo_s = $signed({2'b00, r_c00, {F{1'b0}}}) + (W+2)'(plo);
        assign n_hi_s = $signed({2'b00, r_c01, {F{1'b0}}}) + (W+2)'(phi);

        assign dh  = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});
        assign p2  = dh * $signed({1'b0, r_wy2});
        assign p2s = p2 >>> F;
        assign n_n = r_lo + p2s[W-1:0];

        assign sh = d_eff - DW'(1) - DW'(gi);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ix   <= ix;
                r_row0 <= n_row0;
                r_row1 <= n_row1;
                r_sqx  <= fxx[2*F-1:F];
                r_sqy  <= fyy[2*F-1:F];
                r_tx   <= n_tx;
                r_ty   <= n_ty;

                r_c00  <= n_c00;
                r_c10  <= n_c10;
                r_c01  <= n_c01;
                r_c11  <= n_c11;
                r_wx   <= wxp[2*F:F];
                r_wy   <= wyp[2*F:F];

                r_lo   <= n_lo_s[W-1:0];
                r_hi   <= n_hi_s[W-1:0];
                r_wy2  <= r_wy;

                r_n    <= n_n;

                if (DW'(gi) < d_eff) begin
                    r_term[gi] <= AW'(r_n) << sh;
                end else begin
                    r_term[gi] <= '0;
                end
            end
        end
    end

    // octave sum and normalization
    logic [AW-1:0]   n_acc;
    logic [XW-1:0]   r_xn, r_xn2, r_qe, r_rem;
    logic [XW+S:0]   r_p;
    logic [XW+S:0]   n_p;
    logic [XW+M-1:0] qd;
    logic [XW-1:0]   n_qe, n_rem, n_q;
    logic [NOISE_W-1:0] r_noise;

    always_comb begin
        n_acc = '0;
        for (int k = 0; k < M; k++) begin
            n_acc = n_acc + r_term[k];
        end
    end

    assign n_p   = r_xn * rcp_tab[d_eff];
    assign n_qe  = r_p[XW+S-1:S];
    assign qd    = n_qe * denom;
    assign n_rem = r_xn2 - qd[XW-1:0];
    assign n_q   = (r_rem >= XW'(denom)) ? r_qe + XW'(1) : r_qe;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xn    <= n_acc[AW-1:F-8];
            r_p     <= n_p;
            r_xn2   <= r_xn;
            r_qe    <= n_qe;
            r_rem   <= n_rem;
            r_noise <= n_q[NOISE_W-1:0];
        end
    end

    assign o_noise_value = r_noise;

endmodule
